/* rtl/core/ffba_pkg.sv */
`default_nettype none
package ffba_pkg;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_SIZE     = 3'd1,
		ST_ARENA_FULL   = 3'd2,
		ST_TABLE_FULL   = 3'd3,
		ST_ALREADY_FREE = 3'd4,
		ST_UNKNOWN      = 3'd5,
		ST_RELEASED     = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_FREE    = 2'd1,
		MODE_REALLOC = 2'd2,
		MODE_UNUSED  = 2'd3
	} mode_t;

	localparam logic [6:0]  HEADER_RESET = 7'd24;
	localparam logic [25:0] ARENA_RESET  = 26'd26214400;
	localparam logic [2:0]  ADDR_HEADER  = 3'd0;

endpackage
`default_nettype wire

/* rtl/core/ffba_cell.sv */
`default_nettype none
// One table entry of the rotating ring; it takes its neighbor's entry on each shift.
module ffba_cell #(
	parameter int W = 26
) (
	input  wire logic         clk,
	input  wire logic         shift,
	input  wire logic [W-1:0] start_in,
	input  wire logic [W-1:0] len_in,
	input  wire logic         busy_in,
	output logic      [W-1:0] start_q,
	output logic      [W-1:0] len_q,
	output logic              busy_q
);
	always_ff @(posedge clk) begin
		if (shift) begin
			start_q <= start_in;
			len_q   <= len_in;
			busy_q  <= busy_in;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/first_fit_block_allocator.sv */
`default_nettype none
// Channel   Dir  Payload
// s_*       in   tuser: mode; tdata: request_size, block_address
// m_*       out  tuser: status; tdata: address, copy_from, copy_bytes, clear_from, clear_bytes
// APB       in   0x0 header_bytes, 0x4 arena_bytes
// An item passes through one lookup revolution of the entry ring, a decision step, an update
// revolution, and a step that hands the result to the output register.
// The ring moves one entry per cycle during both revolutions; a new item is taken only once the last is done.
// Reset empties the table (entry count and arena end to zero); entries need no clearing.
// A new item is taken while an earlier result still waits on m_tready.
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS  = 64,
	parameter int OFFSET_BITS = 26
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [1:0]   s_tuser,   // [1:0] mode
	input  wire logic [55:0]  s_tdata,   // [25:0] request_size, [50:26] block_address
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [2:0]   m_tuser,   // [2:0] status
	output logic      [127:0] m_tdata    // [24:0] address, [49:25] copy_from,
	                                     // [75:50] copy_bytes, [100:76] clear_from,
	                                     // [126:101] clear_bytes
);
	localparam int OW = OFFSET_BITS;
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int NW = $clog2(MAX_BLOCKS + 1);
	localparam int CW = (OFFSET_BITS > 26) ? OFFSET_BITS : 26;
	localparam int EW = CW + 2;
	localparam logic [EW-1:0] ADDR_LIM = EW'(1) << (OFFSET_BITS - 1);
	localparam logic [IW-1:0] LAST_STEP = IW'(MAX_BLOCKS - 1);
	localparam logic [NW-1:0] FULL_COUNT = NW'(MAX_BLOCKS);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_APPLY, S_DONE} state_t;

	state_t        state_q;
	logic [IW-1:0] step_q;
	logic [NW-1:0] count_q;
	logic [OW-1:0] arena_end_q;
	logic [6:0]    header_q;
	logic [25:0]   arena_q;
	logic          m_tvalid_q;

	logic [1:0]    mode_q;
	logic [25:0]   size_q;
	logic [24:0]   baddr_q;

	logic          find_hit_q, find_busy_q, fit_hit_q;
	logic [IW-1:0] find_idx_q, fit_idx_q;
	logic [OW-1:0] find_len_q, fit_pay_q;

	logic          set_en_q, clr_en_q, app_en_q;
	logic [IW-1:0] set_idx_q, clr_idx_q, app_idx_q;
	logic [OW-1:0] app_start_q, app_len_q;
	logic [24:0]   r_addr_q, r_cfrom_q, r_clfrom_q;
	logic [25:0]   r_cbytes_q, r_clbytes_q;
	ffba_pkg::status_t r_status_q;

	logic [OW-1:0] c_start [MAX_BLOCKS];
	logic [OW-1:0] c_len   [MAX_BLOCKS];
	logic          c_busy  [MAX_BLOCKS];
	logic [OW-1:0] h_start, h_len;
	logic          h_busy, shift;

	assign shift = (state_q == S_SCAN) || (state_q == S_APPLY);

	// The head entry goes back in at the tail, updated on the update revolution.
	always_comb begin
		h_start = c_start[0];
		h_len   = c_len[0];
		h_busy  = c_busy[0];
		if (state_q == S_APPLY) begin
			if (app_en_q && step_q == app_idx_q) begin
				h_start = app_start_q;
				h_len   = app_len_q;
				h_busy  = 1'b1;
			end
			if (set_en_q && step_q == set_idx_q) h_busy = 1'b1;
			if (clr_en_q && step_q == clr_idx_q) h_busy = 1'b0;
		end
	end

	for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
		if (j == MAX_BLOCKS - 1) begin : g_tail
			ffba_cell #(.W(OW)) u_cell (
				.clk(clk), .shift(shift),
				.start_in(h_start), .len_in(h_len), .busy_in(h_busy),
				.start_q(c_start[j]), .len_q(c_len[j]), .busy_q(c_busy[j])
			);
		end else begin : g_mid
			ffba_cell #(.W(OW)) u_cell (
				.clk(clk), .shift(shift),
				.start_in(c_start[j+1]), .len_in(c_len[j+1]), .busy_in(c_busy[j+1]),
				.start_q(c_start[j]), .len_q(c_len[j]), .busy_q(c_busy[j])
			);
		end
	end

	// Lookup on the head entry.
	logic [OW-1:0] head_pay;
	logic          head_valid, head_match, head_fit;
	assign head_pay   = OW'(c_start[0] + OW'(header_q));
	assign head_valid = NW'(step_q) < count_q;
	assign head_match = head_valid && (CW'(head_pay) == CW'(baddr_q));
	assign head_fit   = head_valid && !c_busy[0] && (CW'(c_len[0]) >= CW'(size_q));

	// Decision.
	logic [EW-1:0] end_sum, limit;
	logic [OW-1:0] app_pay;
	logic          size0, grow;
	ffba_pkg::status_t a_stat, d_stat;
	logic          a_set, a_app, d_set, d_clr, d_app;
	logic [24:0]   a_addr, d_addr, d_cfrom, d_clfrom;
	logic [25:0]   d_cbytes, d_clbytes;

	assign end_sum = EW'(arena_end_q) + EW'(header_q) + EW'(size_q);
	assign limit   = (EW'(arena_q) < ADDR_LIM) ? EW'(arena_q) : ADDR_LIM;
	assign app_pay = OW'(arena_end_q + OW'(header_q));
	assign size0   = (size_q == 26'd0);
	assign grow    = CW'(size_q) >= CW'(find_len_q);

	always_comb begin
		a_stat = ffba_pkg::ST_OK;
		a_set  = 1'b0;
		a_app  = 1'b0;
		a_addr = 25'd0;
		priority if (size0) begin
			a_stat = ffba_pkg::ST_BAD_SIZE;
		end else if (fit_hit_q) begin
			a_set  = 1'b1;
			a_addr = 25'(CW'(fit_pay_q));
		end else if (count_q >= FULL_COUNT) begin
			a_stat = ffba_pkg::ST_TABLE_FULL;
		end else if (end_sum > limit) begin
			a_stat = ffba_pkg::ST_ARENA_FULL;
		end else begin
			a_app  = 1'b1;
			a_addr = 25'(CW'(app_pay));
		end
	end

	always_comb begin
		d_stat    = ffba_pkg::ST_OK;
		d_set     = 1'b0;
		d_clr     = 1'b0;
		d_app     = 1'b0;
		d_addr    = 25'd0;
		d_cfrom   = 25'd0;
		d_cbytes  = 26'd0;
		d_clfrom  = 25'd0;
		d_clbytes = 26'd0;
		unique case (ffba_pkg::mode_t'(mode_q))
			ffba_pkg::MODE_ALLOC: begin
				d_stat = a_stat;
				d_set  = a_set;
				d_app  = a_app;
				d_addr = a_addr;
			end
			ffba_pkg::MODE_FREE: begin
				priority if (!find_hit_q) begin
					d_stat = ffba_pkg::ST_UNKNOWN;
				end else if (!find_busy_q) begin
					d_stat = ffba_pkg::ST_ALREADY_FREE;
				end else begin
					d_clr     = 1'b1;
					d_addr    = baddr_q;
					d_clfrom  = baddr_q;
					d_clbytes = 26'(CW'(find_len_q));
				end
			end
			ffba_pkg::MODE_REALLOC: begin
				priority if (!find_hit_q) begin
					d_stat = ffba_pkg::ST_UNKNOWN;
				end else if (!find_busy_q) begin
					d_stat = a_stat;
					d_set  = a_set;
					d_app  = a_app;
					d_addr = a_addr;
				end else if (size0) begin
					d_stat    = ffba_pkg::ST_RELEASED;
					d_clr     = 1'b1;
					d_clfrom  = baddr_q;
					d_clbytes = 26'(CW'(find_len_q));
				end else if (grow) begin
					d_stat = a_stat;
					d_set  = a_set;
					d_app  = a_app;
					d_addr = a_addr;
					if (a_stat == ffba_pkg::ST_OK) begin
						d_clr     = 1'b1;
						d_cfrom   = baddr_q;
						d_cbytes  = 26'(CW'(find_len_q));
						d_clfrom  = baddr_q;
						d_clbytes = 26'(CW'(find_len_q));
					end
				end else begin
					d_addr    = baddr_q;
					d_clfrom  = 25'(26'(baddr_q) + size_q);
					d_clbytes = 26'(CW'(find_len_q) - CW'(size_q));
				end
			end
			default: d_stat = ffba_pkg::ST_BAD_SIZE;
		endcase
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			arena_end_q <= '0;
			header_q    <= ffba_pkg::HEADER_RESET;
			arena_q     <= ffba_pkg::ARENA_RESET;
			m_tvalid_q  <= 1'b0;
			find_hit_q  <= 1'b0;
			fit_hit_q   <= 1'b0;
			set_en_q    <= 1'b0;
			clr_en_q    <= 1'b0;
			app_en_q    <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2] == ffba_pkg::ADDR_HEADER[2]) header_q <= pwdata[6:0];
				else arena_q <= pwdata[25:0];
			end
			if (state_q == S_DONE && (!m_tvalid_q || m_tready)) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q    <= S_SCAN;
						step_q     <= '0;
						find_hit_q <= 1'b0;
						fit_hit_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (head_match && !find_hit_q) find_hit_q <= 1'b1;
					if (head_fit && !fit_hit_q) fit_hit_q <= 1'b1;
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						state_q <= S_DECIDE;
					end else begin
						step_q <= step_q + IW'(1);
					end
				end
				S_DECIDE: begin
					set_en_q <= d_set;
					clr_en_q <= d_clr;
					app_en_q <= d_app;
					if (d_app) begin
						count_q     <= count_q + NW'(1);
						arena_end_q <= OW'(end_sum);
					end
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						state_q <= S_DONE;
					end else begin
						step_q <= step_q + IW'(1);
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			mode_q  <= s_tuser;
			size_q  <= s_tdata[25:0];
			baddr_q <= s_tdata[50:26];
		end
		if (state_q == S_SCAN) begin
			if (head_match && !find_hit_q) begin
				find_idx_q  <= step_q;
				find_busy_q <= c_busy[0];
				find_len_q  <= c_len[0];
			end
			if (head_fit && !fit_hit_q) begin
				fit_idx_q <= step_q;
				fit_pay_q <= head_pay;
			end
		end
		if (state_q == S_DECIDE) begin
			set_idx_q   <= fit_idx_q;
			clr_idx_q   <= find_idx_q;
			app_idx_q   <= IW'(count_q);
			app_start_q <= arena_end_q;
			app_len_q   <= OW'(CW'(size_q));
			r_status_q  <= d_stat;
			r_addr_q    <= d_addr;
			r_cfrom_q   <= d_cfrom;
			r_cbytes_q  <= d_cbytes;
			r_clfrom_q  <= d_clfrom;
			r_clbytes_q <= d_clbytes;
		end
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tuser <= r_status_q;
			m_tdata <= {1'b0, r_clbytes_q, r_clfrom_q, r_cbytes_q, r_cfrom_q, r_addr_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign s_tready = (state_q == S_IDLE);
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == ffba_pkg::ADDR_HEADER[2]) ? {25'd0, header_q}
	                                                         : {6'd0, arena_q};
endmodule
`default_nettype wire
